>>> hw/rtl/coincidence_event_builder_pairs_assert.svh
// Assertion macros shared by the coincidence event builder RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef COINCIDENCE_EVENT_BUILDER_PAIRS_ASSERT_SVH
`define COINCIDENCE_EVENT_BUILDER_PAIRS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CEB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ceb_pkg.sv
// Package for the coincidence event builder: sizes, field offsets, register codes
// and the controller state type. No dependencies.
package ceb_pkg;

  localparam int NUM_SLOTS         = 8;
  localparam int CHANNELS_PER_SLOT = 16;
  localparam int MAX_HITS          = 8;
  localparam int MATRIX_BINS       = 4096;
  localparam int SLOT_BASE         = 3;
  localparam int NUM_COEF          = 3;

  localparam int ROWS       = NUM_SLOTS * CHANNELS_PER_SLOT;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HIT_IDX_W  = $clog2(MAX_HITS);
  localparam int HIT_CNT_W  = $clog2(MAX_HITS + 1);

  localparam int BIN_W      = 12;
  localparam int E_W        = 40;
  localparam int TS_W       = 48;
  localparam int COEF_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // Input tdata layout, lowest field first.
  localparam int IN_SLOT_LSB    = 0;
  localparam int IN_CHAN_LSB    = 4;
  localparam int IN_RAW_LSB     = 8;
  localparam int IN_DITHER_LSB  = 24;
  localparam int IN_TS_LSB      = 40;
  localparam int IN_SEL_LSB     = 88;
  localparam int IN_COEF_LSB    = 90;
  localparam int IN_DATA_W      = 144;
  localparam int OUT_DATA_W     = 24;

  localparam logic signed [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
  localparam logic signed [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_WINDOW = 3'd0,
    CFG_ENERGY_LOW  = 3'd1,
    CFG_ENERGY_HIGH = 3'd2,
    CFG_BIN_ORIGIN  = 3'd3,
    CFG_BIN_SCALE   = 3'd4,
    CFG_FLAG_MASK   = 3'd5
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC,
    ST_E_RD,
    ST_E_SEL,
    ST_E_MX,
    ST_E_AX,
    ST_E_MY,
    ST_E_AY,
    ST_E_PUSH,
    ST_E_FIN,
    ST_C_RD,
    ST_C_M1,
    ST_C_M2,
    ST_C_M3,
    ST_C_M4,
    ST_C_WR
  } ceb_state_t;

  typedef struct packed {
    logic [3:0]            ch;
    logic signed [E_W-1:0] en;
  } hit_entry_t;

endpackage

>>> hw/rtl/coincidence_event_builder_pairs.sv
// Coincidence event builder: calibrates hits, groups them into time windows and emits
// gamma-gamma matrix bin pairs for closed events. Depends on ceb_pkg and the assert header.
//
// Channel  Direction  Payload
// in_      slave      tuser: action; tdata: slot, channel, raw, dither, timestamp, sel, coef
// out_     master     tdata: x_bin, y_bin; tlast: last pair of the closed event
// cfg_     slave      index 0..5 and data, always ready
//
// A coefficient write is done at decode; a hit that joins or opens an event goes through
// coefficient memory read, three shared multiply passes, sum and store.
// Closing an event walks every ordered hit pair: a self pair is only read, a pair with
// no flagged hit is read and checked, and a candidate pair is binned and pushed; after up
// to 56 pairs the held pair is released, then the new hit is calibrated and, if kept, stored.
// After reset a pass zeroes every coefficient row; no input transfer is taken meanwhile.
// A stalled output holds the walk while a pair is held and a second is ready, or at its end.
`include "coincidence_event_builder_pairs_assert.svh"

module coincidence_event_builder_pairs (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [3:0] slot, [7:4] channel, [23:8] raw_energy, [39:24] dither, [87:40] timestamp,
  // [89:88] coef_select, [137:90] coef_value, [143:138] zero
  input  logic [ceb_pkg::IN_DATA_W-1:0]          in_tdata,
  // [0] action
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [11:0] x_bin, [23:12] y_bin
  output logic [ceb_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                   out_tlast,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ceb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ceb_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int E_W    = ceb_pkg::E_W;
  localparam int BIN_W  = ceb_pkg::BIN_W;
  localparam int TS_W   = ceb_pkg::TS_W;
  localparam int COEF_W = ceb_pkg::COEF_W;

  ceb_pkg::ceb_state_t state_r, state_nxt;

  // Configuration registers.
  logic [31:0]           twin_r;
  logic signed [E_W-1:0] elow_r, ehigh_r, borg_r;
  logic [31:0]           bscale_r;
  logic [15:0]           fmask_r;

  // Latched input item.
  logic                          act_r, map_r;
  logic [3:0]                    ch_r;
  logic [31:0]                   e_r;
  logic [TS_W-1:0]               ts_r;
  logic [1:0]                    sel_r;
  logic [COEF_W-1:0]             coef_r;
  logic [ceb_pkg::ROW_W-1:0]     row_r, clr_cnt_r;

  // Event state.
  logic                              open_r;
  logic [TS_W-1:0]                   start_r;
  logic [ceb_pkg::HIT_CNT_W-1:0]     cnt_r;
  logic [ceb_pkg::HIT_IDX_W-1:0]     ei_r, ej_r;

  // Memories.
  logic [ceb_pkg::NUM_COEF-1:0][COEF_W-1:0] cal_mem [ceb_pkg::ROWS];
  logic [ceb_pkg::NUM_COEF-1:0][COEF_W-1:0] cal_q_r;
  ceb_pkg::hit_entry_t hit_mem [ceb_pkg::MAX_HITS];
  ceb_pkg::hit_entry_t hi_q_r, hj_q_r;

  // Calibration datapath.
  logic signed [56:0]    mh_r;
  logic [55:0]           ml_r;
  logic signed [E_W-1:0] q_r, lin_r, en_r;

  // Bin datapath.
  logic signed [E_W:0]   dx_r, dy_r;
  logic signed [57:0]    ph_r;
  logic [47:0]           pl_r;
  logic [BIN_W-1:0]      bx_r, by_r;
  logic                  okx_r, oky_r;

  // Pending pair and output register.
  logic                  pend_v_r;
  logic [BIN_W-1:0]      pend_x_r, pend_y_r;
  logic                  out_v_r, out_last_r;
  logic [BIN_W-1:0]      out_x_r, out_y_r;

  // ---------------------------------------------------------------- input decode
  logic [3:0]                in_slot, in_ch;
  logic [3:0]                slot_off;
  logic                      in_map;
  logic [ceb_pkg::ROW_W-1:0] in_row;

  assign in_slot  = in_tdata[ceb_pkg::IN_SLOT_LSB +: 4];
  assign in_ch    = in_tdata[ceb_pkg::IN_CHAN_LSB +: 4];
  assign slot_off = in_slot - 4'(ceb_pkg::SLOT_BASE);
  assign in_map   = (int'(in_slot) >= ceb_pkg::SLOT_BASE) &&
                    (int'(slot_off) < ceb_pkg::NUM_SLOTS) &&
                    (int'(in_ch) < ceb_pkg::CHANNELS_PER_SLOT);
  assign in_row   = ceb_pkg::ROW_W'(int'(slot_off) * ceb_pkg::CHANNELS_PER_SLOT + int'(in_ch));

  // ---------------------------------------------------------------- shared decisions
  logic [TS_W-1:0] ts_gap;
  logic            fits;
  logic            fi, fj;
  logic [ceb_pkg::HIT_CNT_W-1:0] ei_inc, ej_inc;
  logic            last_pair, pair_ok, out_free;
  logic            keep;

  assign ts_gap    = (ts_r >= start_r) ? (ts_r - start_r) : (start_r - ts_r);
  assign fits      = ts_gap <= {{(TS_W-32){1'b0}}, twin_r};
  assign fi        = fmask_r[hi_q_r.ch];
  assign fj        = fmask_r[hj_q_r.ch];
  assign ei_inc    = ceb_pkg::HIT_CNT_W'(ei_r) + 1'b1;
  assign ej_inc    = ceb_pkg::HIT_CNT_W'(ej_r) + 1'b1;
  assign last_pair = (ej_inc >= cnt_r) && (ei_inc >= cnt_r);
  assign pair_ok   = okx_r && oky_r;
  assign out_free  = !out_v_r || out_tready;
  assign keep      = (en_r >= elow_r) && (en_r <= ehigh_r) &&
                     (cnt_r < ceb_pkg::HIT_CNT_W'(ceb_pkg::MAX_HITS));

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ceb_pkg::ST_CLEAR: begin
        if (clr_cnt_r == ceb_pkg::ROW_W'(ceb_pkg::ROWS - 1)) state_nxt = ceb_pkg::ST_IDLE;
      end
      ceb_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ceb_pkg::ST_DEC;
      end
      ceb_pkg::ST_DEC: begin
        if (!map_r || act_r)       state_nxt = ceb_pkg::ST_IDLE;
        else if (!open_r || fits)  state_nxt = ceb_pkg::ST_C_RD;
        else if (cnt_r == '0)      state_nxt = ceb_pkg::ST_E_FIN;
        else                       state_nxt = ceb_pkg::ST_E_RD;
      end
      ceb_pkg::ST_E_RD: begin
        if (ei_r != ej_r)   state_nxt = ceb_pkg::ST_E_SEL;
        else if (last_pair) state_nxt = ceb_pkg::ST_E_FIN;
      end
      ceb_pkg::ST_E_SEL: begin
        if (fi || fj)       state_nxt = ceb_pkg::ST_E_MX;
        else if (last_pair) state_nxt = ceb_pkg::ST_E_FIN;
        else                state_nxt = ceb_pkg::ST_E_RD;
      end
      ceb_pkg::ST_E_MX: state_nxt = ceb_pkg::ST_E_AX;
      ceb_pkg::ST_E_AX: state_nxt = ceb_pkg::ST_E_MY;
      ceb_pkg::ST_E_MY: state_nxt = ceb_pkg::ST_E_AY;
      ceb_pkg::ST_E_AY: state_nxt = ceb_pkg::ST_E_PUSH;
      ceb_pkg::ST_E_PUSH: begin
        if (!pair_ok || !pend_v_r || out_free) begin
          state_nxt = last_pair ? ceb_pkg::ST_E_FIN : ceb_pkg::ST_E_RD;
        end
      end
      ceb_pkg::ST_E_FIN: begin
        if (!pend_v_r || out_free) state_nxt = ceb_pkg::ST_C_RD;
      end
      ceb_pkg::ST_C_RD: state_nxt = ceb_pkg::ST_C_M1;
      ceb_pkg::ST_C_M1: state_nxt = ceb_pkg::ST_C_M2;
      ceb_pkg::ST_C_M2: state_nxt = ceb_pkg::ST_C_M3;
      ceb_pkg::ST_C_M3: state_nxt = ceb_pkg::ST_C_M4;
      ceb_pkg::ST_C_M4: state_nxt = ceb_pkg::ST_C_WR;
      ceb_pkg::ST_C_WR: state_nxt = ceb_pkg::ST_IDLE;
      default:          state_nxt = ceb_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  logic adv, push_new, push_old, fin_out, restart, coef_we, hit_we;

  always_comb begin
    adv      = 1'b0;
    push_new = 1'b0;
    push_old = 1'b0;
    fin_out  = 1'b0;
    restart  = 1'b0;
    coef_we  = 1'b0;
    hit_we   = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      ceb_pkg::ST_IDLE: in_tready = 1'b1;
      ceb_pkg::ST_DEC: begin
        coef_we = map_r && act_r && (int'(sel_r) < ceb_pkg::NUM_COEF);
        restart = map_r && !act_r && !open_r;
      end
      ceb_pkg::ST_E_RD:  adv = (ei_r == ej_r);
      ceb_pkg::ST_E_SEL: adv = !(fi || fj);
      ceb_pkg::ST_E_PUSH: begin
        push_new = pair_ok && (!pend_v_r || out_free);
        push_old = push_new && pend_v_r;
        adv      = !pair_ok || push_new;
      end
      ceb_pkg::ST_E_FIN: begin
        fin_out = pend_v_r && out_free;
        restart = !pend_v_r || out_free;
      end
      ceb_pkg::ST_C_WR: hit_we = keep;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- shared multipliers
  logic [COEF_W-1:0]   mul_a;
  logic signed [56:0]  mh_c;
  logic [55:0]         ml_c;
  logic signed [80:0]  cfull;
  logic signed [57:0]  quad, csum;
  logic signed [E_W-1:0] csat;

  always_comb begin
    case (state_r)
      ceb_pkg::ST_C_M1: mul_a = cal_q_r[2];
      ceb_pkg::ST_C_M2: mul_a = cal_q_r[1];
      ceb_pkg::ST_C_M3: mul_a = {q_r[E_W-1:16], 8'b0, q_r[15:0]};
      default:          mul_a = '0;
    endcase
  end

  // High part signed, low part unsigned: a = hi * 2^24 + lo.
  assign mh_c  = $signed(mul_a[47:24]) * $signed({1'b0, e_r});
  assign ml_c  = mul_a[23:0] * e_r;
  assign cfull = $signed({mh_r, 24'b0}) + $signed({25'b0, ml_r});
  assign quad  = $signed({mh_r[56], mh_r}) + $signed({18'b0, ml_r[55:16]});
  assign csum  = quad + $signed({{34{cal_q_r[0][47]}}, cal_q_r[0][47:24]})
                      + $signed({{18{lin_r[E_W-1]}}, lin_r});

  always_comb begin
    if (csum > $signed({{18{ceb_pkg::E_MAX[E_W-1]}}, ceb_pkg::E_MAX}))
      csat = ceb_pkg::E_MAX;
    else if (csum < $signed({{18{ceb_pkg::E_MIN[E_W-1]}}, ceb_pkg::E_MIN}))
      csat = ceb_pkg::E_MIN;
    else
      csat = csum[E_W-1:0];
  end

  // Bin: floor(d * scale / 2^32) with d split at bit 16.
  logic signed [E_W:0]   bd;
  logic signed [57:0]    ph_c;
  logic [47:0]           pl_c;
  logic signed [58:0]    bt;
  logic                  bok;
  logic signed [E_W-1:0] xe, ye;

  assign bd   = (state_r == ceb_pkg::ST_E_MY) ? dy_r : dx_r;
  assign ph_c = $signed(bd[E_W:16]) * $signed({1'b0, bscale_r});
  assign pl_c = bd[15:0] * bscale_r;
  assign bt   = $signed({ph_r[57], ph_r}) + $signed({27'b0, pl_r[47:16]});
  assign bok  = !bt[58] && (bt[58:16] < 43'(ceb_pkg::MATRIX_BINS));
  assign xe   = fi ? hj_q_r.en : hi_q_r.en;
  assign ye   = fi ? hi_q_r.en : hj_q_r.en;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ceb_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      twin_r    <= '0;
      elow_r    <= '0;
      ehigh_r   <= ceb_pkg::E_MAX;
      borg_r    <= '0;
      bscale_r  <= 32'h0001_0000;
      fmask_r   <= '0;
      open_r    <= 1'b0;
      start_r   <= '0;
      cnt_r     <= '0;
      ei_r      <= '0;
      ej_r      <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (ceb_pkg::cfg_reg_t'(cfg_index))
          ceb_pkg::CFG_TIME_WINDOW: twin_r   <= cfg_data[31:0];
          ceb_pkg::CFG_ENERGY_LOW:  elow_r   <= $signed(cfg_data);
          ceb_pkg::CFG_ENERGY_HIGH: ehigh_r  <= $signed(cfg_data);
          ceb_pkg::CFG_BIN_ORIGIN:  borg_r   <= $signed(cfg_data);
          ceb_pkg::CFG_BIN_SCALE:   bscale_r <= cfg_data[31:0];
          ceb_pkg::CFG_FLAG_MASK:   fmask_r  <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (state_r == ceb_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;

      if (state_r == ceb_pkg::ST_DEC && map_r && !act_r && open_r && !fits) begin
        ei_r <= '0;
        ej_r <= '0;
      end else if (adv) begin
        if (ej_inc < cnt_r) begin
          ej_r <= ej_r + 1'b1;
        end else begin
          ei_r <= ei_r + 1'b1;
          ej_r <= '0;
        end
      end

      if (restart) begin
        open_r  <= 1'b1;
        cnt_r   <= '0;
        start_r <= ts_r;
      end else if (hit_we) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if (push_old || fin_out) begin
        out_v_r    <= 1'b1;
        out_x_r    <= pend_x_r;
        out_y_r    <= pend_y_r;
        out_last_r <= fin_out;
      end else if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      if (push_new) begin
        pend_v_r <= 1'b1;
        pend_x_r <= bx_r;
        pend_y_r <= by_r;
      end else if (fin_out) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r  <= in_tuser;
      map_r  <= in_map;
      row_r  <= in_row;
      ch_r   <= in_ch;
      e_r    <= {in_tdata[ceb_pkg::IN_RAW_LSB +: 16], in_tdata[ceb_pkg::IN_DITHER_LSB +: 16]};
      ts_r   <= in_tdata[ceb_pkg::IN_TS_LSB +: TS_W];
      sel_r  <= in_tdata[ceb_pkg::IN_SEL_LSB +: 2];
      coef_r <= in_tdata[ceb_pkg::IN_COEF_LSB +: COEF_W];
    end
    if (state_r == ceb_pkg::ST_C_M1 || state_r == ceb_pkg::ST_C_M2 ||
        state_r == ceb_pkg::ST_C_M3) begin
      mh_r <= mh_c;
      ml_r <= ml_c;
    end
    if (state_r == ceb_pkg::ST_C_M2) q_r   <= cfull[79:40];
    if (state_r == ceb_pkg::ST_C_M3) lin_r <= cfull[79:40];
    if (state_r == ceb_pkg::ST_C_M4) en_r  <= csat;
    if (state_r == ceb_pkg::ST_E_SEL) begin
      dx_r <= $signed({xe[E_W-1], xe}) - $signed({borg_r[E_W-1], borg_r});
      dy_r <= $signed({ye[E_W-1], ye}) - $signed({borg_r[E_W-1], borg_r});
    end
    if (state_r == ceb_pkg::ST_E_MX || state_r == ceb_pkg::ST_E_MY) begin
      ph_r <= ph_c;
      pl_r <= pl_c;
    end
    if (state_r == ceb_pkg::ST_E_AX) begin
      bx_r  <= bt[16 +: BIN_W];
      okx_r <= bok;
    end
    if (state_r == ceb_pkg::ST_E_AY) begin
      by_r  <= bt[16 +: BIN_W];
      oky_r <= bok;
    end
  end

  // ---------------------------------------------------------------- memories
  // Coefficient memory: one row per slot and channel, one 48-bit lane per coefficient.
  always_ff @(posedge clk) begin
    if (state_r == ceb_pkg::ST_CLEAR) begin
      cal_mem[clr_cnt_r] <= '0;
    end else if (coef_we) begin
      for (int k = 0; k < ceb_pkg::NUM_COEF; k++) begin
        if (sel_r == 2'(k)) cal_mem[row_r][k] <= coef_r;
      end
    end
    if (state_r == ceb_pkg::ST_C_RD) cal_q_r <= cal_mem[row_r];
  end

  // Hit store: written at the fill count, read at two pair indices.
  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[cnt_r[ceb_pkg::HIT_IDX_W-1:0]] <= '{ch: ch_r, en: en_r};
    end
    if (state_r == ceb_pkg::ST_E_RD) begin
      hi_q_r <= hit_mem[ei_r];
      hj_q_r <= hit_mem[ej_r];
    end
  end

  // ---------------------------------------------------------------- ports
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------- assertions
  `CEB_ASSERT_NOW(a_idle_no_pend, state_r == ceb_pkg::ST_IDLE, !pend_v_r, "pair left pending at idle")
  `CEB_ASSERT_NOW(a_clear_blocks, state_r == ceb_pkg::ST_CLEAR, !in_tready, "input taken during clear")
  `CEB_ASSERT_NOW(a_pair_indices, state_r == ceb_pkg::ST_E_SEL, (ei_r != ej_r) && (ceb_pkg::HIT_CNT_W'(ei_r) < cnt_r) && (ceb_pkg::HIT_CNT_W'(ej_r) < cnt_r), "bad pair indices")

endmodule

>>> verif/coincidence_event_builder_pairs_tb.sv
// Self-checking testbench for the coincidence event builder: drives hits and coefficient
// writes, predicts the matrix bin pairs and checks every result transfer.
// Depends on ceb_pkg and the coincidence_event_builder_pairs RTL.
`timescale 1ns / 1ps

module coincidence_event_builder_pairs_tb;

  localparam int  LIMIT_CYCLES = 1_500_000;
  localparam int  DRAIN_CYCLES = 500;
  localparam int  ITEMS_PER_PHASE = 58;
  localparam logic [47:0] ONE_Q40 = 48'h010000000000;

  typedef enum logic { ACT_HIT = 1'b0, ACT_COEF = 1'b1 } action_t;
  typedef enum logic [1:0] {
    SEL_OFFSET = 2'd0, SEL_LINEAR = 2'd1, SEL_QUAD = 2'd2, SEL_NONE = 2'd3
  } coef_sel_t;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic        last;
  } bin_pair_t;

  class pair_scoreboard;
    logic [31:0]                    window;
    logic signed [ceb_pkg::E_W-1:0] e_low, e_high, origin;
    logic [31:0]                    scale;
    logic [15:0]                    mask;
    bit                             open;
    logic [47:0]                    start_ts;
    int                             count;
    logic [3:0]                     chans[ceb_pkg::MAX_HITS];
    logic signed [ceb_pkg::E_W-1:0] ens[ceb_pkg::MAX_HITS];
    logic signed [47:0]             coef_tab[ceb_pkg::ROWS*ceb_pkg::NUM_COEF];
    bin_pair_t                      expected_pairs[$];
    int                             errors;

    function new();
      window = 0; e_low = 0; e_high = ceb_pkg::E_MAX; origin = 0; scale = 65536; mask = 0;
      open = 0; start_ts = 0; count = 0; errors = 0;
      foreach (coef_tab[k]) coef_tab[k] = 0;
    endfunction

    function void set_reg(ceb_pkg::cfg_reg_t idx, logic [39:0] v);
      case (idx)
        ceb_pkg::CFG_TIME_WINDOW: window = v[31:0];
        ceb_pkg::CFG_ENERGY_LOW:  e_low = v;
        ceb_pkg::CFG_ENERGY_HIGH: e_high = v;
        ceb_pkg::CFG_BIN_ORIGIN:  origin = v;
        ceb_pkg::CFG_BIN_SCALE:   scale = v[31:0];
        ceb_pkg::CFG_FLAG_MASK:   mask = v[15:0];
        default: ;
      endcase
    endfunction

    function logic signed [ceb_pkg::E_W-1:0] calibrate(int row, logic [15:0] raw,
                                                       logic [15:0] dith);
      logic signed [127:0] e, c0, c1, c2, q, sum;
      e = $signed({96'b0, raw, dith});
      c0 = coef_tab[row*3];
      c1 = coef_tab[row*3+1];
      c2 = coef_tab[row*3+2];
      q = (c2 * e) >>> 40;
      sum = (c0 >>> 24) + ((c1 * e) >>> 40) + ((q * e) >>> 16);
      if (sum > ceb_pkg::E_MAX) sum = ceb_pkg::E_MAX;
      if (sum < ceb_pkg::E_MIN) sum = ceb_pkg::E_MIN;
      return sum[ceb_pkg::E_W-1:0];
    endfunction

    function bit to_bin(logic signed [ceb_pkg::E_W-1:0] en, output logic [11:0] b);
      logic signed [127:0] d, r;
      d = en;
      d = d - origin;
      r = (d * $signed({96'b0, scale})) >>> 32;
      b = r[11:0];
      return (r >= 0 && r < ceb_pkg::MATRIX_BINS);
    endfunction

    function void add_hit(int row, logic [3:0] ch, logic [15:0] raw, logic [15:0] dith);
      logic signed [ceb_pkg::E_W-1:0] en;
      en = calibrate(row, raw, dith);
      if (en < e_low || en > e_high || count >= ceb_pkg::MAX_HITS) return;
      chans[count] = ch;
      ens[count] = en;
      count++;
    endfunction

    function void close_event();
      bit any;
      int first;
      logic signed [ceb_pkg::E_W-1:0] xe, ye;
      logic [11:0] xb, yb;
      any = 0;
      first = expected_pairs.size();
      if (count < 2) return;
      for (int i = 0; i < count; i++) if (mask[chans[i]]) any = 1;
      if (!any) return;
      for (int i = 0; i < count; i++) begin
        for (int j = 0; j < count; j++) begin
          if (i == j) continue;
          if (mask[chans[i]]) begin
            xe = ens[j]; ye = ens[i];
          end else if (mask[chans[j]]) begin
            xe = ens[i]; ye = ens[j];
          end else begin
            continue;
          end
          if (!to_bin(xe, xb) || !to_bin(ye, yb)) continue;
          expected_pairs.push_back('{x: xb, y: yb, last: 1'b0});
        end
      end
      if (expected_pairs.size() > first) expected_pairs[$].last = 1'b1;
    endfunction

    function void note_input(action_t act, logic [3:0] slot, logic [3:0] ch,
                             logic [15:0] raw, logic [15:0] dith, logic [47:0] ts,
                             coef_sel_t sel, logic [47:0] coef);
      int row;
      logic [47:0] ts_gap;
      // Hits and writes on slots or channels outside the table have no effect at all.
      if (slot < ceb_pkg::SLOT_BASE || slot >= ceb_pkg::SLOT_BASE + ceb_pkg::NUM_SLOTS) return;
      row = (slot - ceb_pkg::SLOT_BASE) * ceb_pkg::CHANNELS_PER_SLOT + ch;
      if (act == ACT_COEF) begin
        if (sel != SEL_NONE) coef_tab[row*3 + sel] = coef;
        return;
      end
      if (open) begin
        ts_gap = (ts >= start_ts) ? ts - start_ts : start_ts - ts;
        if (ts_gap <= {16'b0, window}) begin
          add_hit(row, ch, raw, dith);
          return;
        end
        close_event();
      end
      open = 1;
      count = 0;
      start_ts = ts;
      add_hit(row, ch, raw, dith);
    endfunction

    function void check_pair(logic [11:0] x, logic [11:0] y, logic last);
      bin_pair_t e;
      if (expected_pairs.size() == 0) begin
        if (errors < 10) $display("unexpected pair x=%0d y=%0d last=%0b", x, y, last);
        errors++;
        return;
      end
      e = expected_pairs.pop_front();
      if (e.x !== x || e.y !== y || e.last !== last) begin
        if (errors < 10)
          $display("pair mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   e.x, e.y, e.last, x, y, last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 0;
  logic                           rst_n = 0;
  logic                           in_tvalid = 0;
  logic                           in_tready;
  logic [ceb_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 0;
  logic                           out_tvalid;
  logic                           out_tready = 0;
  logic [ceb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;
  logic                           cfg_valid = 0;
  logic                           cfg_ready;
  logic [ceb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ceb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pair_scoreboard sb = new();
  int             cycles = 0;
  int             burst_left = 0;
  int             stall_mode = 0;
  logic [47:0]    cur_ts = 48'd1000;

  coincidence_event_builder_pairs i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("coincidence_event_builder_pairs_tb: errors");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      sb.check_pair(out_tdata[11:0], out_tdata[23:12], out_tlast);

  // The receiver alternates between always ready, random stalls and a sparse pattern.
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready = 1'b1;
      1: out_tready = $urandom_range(0, 1);
      default: out_tready = (cycles % 4 == 0);
    endcase
  end

  task automatic write_reg(ceb_pkg::cfg_reg_t idx, logic [39:0] v);
    @(negedge clk);
    cfg_valid = 1; cfg_index = idx; cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Drops the input valid so that the last item is not taken again while draining.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 0;
    while (sb.expected_pairs.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send(action_t act, logic [3:0] slot, logic [3:0] ch, logic [15:0] raw,
                      logic [15:0] dith, logic [47:0] ts, coef_sel_t sel, logic [47:0] coef);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1;
    in_tuser = act;
    in_tdata = {6'b0, coef, sel, ts, dith, raw, ch, slot};
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, slot, ch, raw, dith, ts, sel, coef);
  endtask

  task automatic send_hit(logic [3:0] slot, logic [3:0] ch, logic [15:0] raw, logic [47:0] ts);
    send(ACT_HIT, slot, ch, raw, 16'($urandom), ts, coef_sel_t'($urandom_range(0, 3)),
         48'({$urandom, $urandom}));
  endtask

  task automatic send_coef(logic [3:0] slot, logic [3:0] ch, coef_sel_t sel, logic [47:0] v);
    send(ACT_COEF, slot, ch, 16'($urandom), 16'($urandom), 48'({$urandom, $urandom}), sel, v);
  endtask

  task automatic random_item();
    int pick;
    logic [47:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Mostly plausible gains, sometimes arbitrary coefficient bits.
      case ($urandom_range(0, 3))
        0: v = ONE_Q40 + 48'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        1: v = 48'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        2: v = 48'($signed($urandom_range(0, 1 << 30)) - (1 << 29)) << 10;
        default: v = 48'({$urandom, $urandom});
      endcase
      send_coef(4'($urandom_range(pick < 2 ? 0 : 3, pick < 2 ? 15 : 10)), 4'($urandom),
                coef_sel_t'($urandom_range(0, pick == 11 ? 3 : 2)), v);
    end else if (pick < 17) begin
      send_hit(4'($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(11, 15)),
               4'($urandom), 16'($urandom), 48'({$urandom, $urandom}));
    end else begin
      if (pick < 30) cur_ts = cur_ts + 48'($urandom_range(150, 100000));
      else if (pick < 32) cur_ts = 48'({$urandom, $urandom});
      else if (pick < 40 && cur_ts > 50) cur_ts = cur_ts - 48'($urandom_range(0, 50));
      else cur_ts = cur_ts + 48'($urandom_range(0, 40));
      send_hit(4'($urandom_range(3, 10)), 4'($urandom),
               16'(pick < 90 ? $urandom_range(0, 4200) : $urandom), cur_ts);
    end
  endtask

  task automatic program_regs(logic [31:0] win, logic [39:0] lo, logic [39:0] hi,
                              logic [39:0] org, logic [31:0] sc, logic [15:0] msk);
    write_reg(ceb_pkg::CFG_TIME_WINDOW, {8'b0, win});
    write_reg(ceb_pkg::CFG_ENERGY_LOW, lo);
    write_reg(ceb_pkg::CFG_ENERGY_HIGH, hi);
    write_reg(ceb_pkg::CFG_BIN_ORIGIN, org);
    write_reg(ceb_pkg::CFG_BIN_SCALE, {8'b0, sc});
    write_reg(ceb_pkg::CFG_FLAG_MASK, msk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    program_regs(32'd100, 40'd0, ceb_pkg::E_MAX, 40'd0, 32'd65536, 16'h00FF);
    // Unit gain on a few channels, including the corners of the table.
    send_coef(4'd3, 4'd0, SEL_LINEAR, ONE_Q40);
    send_coef(4'd3, 4'd1, SEL_LINEAR, ONE_Q40);
    send_coef(4'd10, 4'd15, SEL_LINEAR, ONE_Q40);
    send_coef(4'd10, 4'd15, SEL_OFFSET, 48'h000100000000);
    send_coef(4'd3, 4'd1, SEL_QUAD, 48'h000000010000);
    send_coef(4'd3, 4'd0, SEL_NONE, 48'hFFFFFFFFFFFF);
    send_coef(4'd2, 4'd0, SEL_LINEAR, 48'hFFFFFFFFFFFF);
    send_hit(4'd3, 4'd0, 16'd0, 48'd0);
    send_hit(4'd3, 4'd1, 16'd100, 48'd10);
    send_hit(4'd10, 4'd15, 16'd4000, 48'd20);
    send_hit(4'd0, 4'd0, 16'hFFFF, 48'd5000);
    send_hit(4'd15, 4'd15, 16'hFFFF, 48'd5000);
    send_hit(4'd11, 4'd3, 16'd5, 48'd5000);
    send_hit(4'd3, 4'd1, 16'hFFFF, 48'd1000);
    // A full event: the ninth hit is dropped.
    for (int k = 0; k < 9; k++) send_hit(4'd3, 4'(k % 2), 16'(200 * k), 48'd2000 + 48'(k));
    send_hit(4'd10, 4'd15, 16'd10, 48'hFFFFFFFFFFFF);
    send_hit(4'd3, 4'd0, 16'd7, 48'd0);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: program_regs(32'd100, 40'd0, ceb_pkg::E_MAX, 40'd0, 32'd65536, 16'h00FF);
        1: program_regs(32'd0, ceb_pkg::E_MIN, ceb_pkg::E_MAX, 40'hFFF0000000, 32'd131072,
                        16'hFFFF);
        2: program_regs(32'hFFFFFFFF, ceb_pkg::E_MIN, ceb_pkg::E_MAX, ceb_pkg::E_MIN,
                        32'hFFFFFFFF, 16'($urandom));
        default: program_regs(32'd60, 40'd100 << 16, 40'd3000 << 16, 40'd50 << 16,
                              32'd32768, 16'h8001);
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) random_item();
      settle();
    end
    program_regs(32'd50, ceb_pkg::E_MIN, ceb_pkg::E_MAX, 40'd0, 32'd0, 16'hFFFF);
    for (int k = 0; k < 20; k++) random_item();
    send_hit(4'd3, 4'd0, 16'd1, cur_ts + 48'd1000000);
    @(negedge clk);
    in_tvalid = 0;
    settle();

    if (sb.errors == 0 && sb.expected_pairs.size() == 0) begin
      $display("coincidence_event_builder_pairs_tb: clean");
    end else begin
      $display("coincidence_event_builder_pairs_tb: errors");
    end
    $finish;
  end

endmodule
